FILE: design/erlp_pkg.sv
// ----------------------------------------------------------------------------
// erlp_pkg
// Shared constants, codes and types of the engine reply line parser.
// ----------------------------------------------------------------------------
package erlp_pkg;

   localparam int CHANNELS_DEF     = 4;
   localparam int MAX_FRACTION_DEF = 5;

   localparam int SLOTS = 6;
   localparam int FCW   = 4;
   localparam int KW    = 3;
   localparam int ACCW  = 41;
   localparam int VW    = ACCW + 3;
   localparam int XW    = 42;

   localparam logic [ACCW-1:0] MAG_CAP = ACCW'(41'h100_0000_0000);
   localparam logic [ACCW-1:0] LIM_POS = ACCW'(33'h0_7fff_ffff);
   localparam logic [ACCW-1:0] LIM_NEG = ACCW'(33'h0_8000_0000);
   localparam logic [SLOTS-1:0] SCALED_SLOTS = 6'b110100;

   localparam logic [7:0] CH_CR    = 8'h0d;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_COMMA = 8'h2c;
   localparam logic [7:0] CH_STAR  = 8'h2a;
   localparam logic [7:0] CH_MINUS = 8'h2d;
   localparam logic [7:0] CH_POINT = 8'h2e;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_H     = 8'h48;
   localparam logic [7:0] CH_S     = 8'h53;
   localparam logic [7:0] CH_LOW   = 8'h20;
   localparam logic [7:0] CH_HIGH  = 8'h7a;

   localparam logic [1:0] CMD_RAC   = 2'd0;
   localparam logic [1:0] CMD_WPE   = 2'd1;
   localparam logic [1:0] CMD_TCO   = 2'd2;
   localparam logic [1:0] CMD_OTHER = 2'd3;

   localparam logic [1:0] PEND_IDLE = 2'd0;

   localparam logic KIND_ECHO   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_UC      = 3'd1;
   localparam logic [2:0] ST_PA      = 3'd2;
   localparam logic [2:0] ST_NA      = 3'd3;
   localparam logic [2:0] ST_PR      = 3'd4;
   localparam logic [2:0] ST_PL      = 3'd5;
   localparam logic [2:0] ST_DF      = 3'd6;
   localparam logic [2:0] ST_UNKNOWN = 3'd7;

   typedef struct packed {
      logic [31:0]    mag;
      logic [FCW-1:0] dx;
      logic           neg;
   } slot_type;

   typedef struct packed {
      logic [1:0]            pending;
      logic [2:0]            pos;
      logic [4:0][7:0]       pfx;
      logic [3:0]            fidx;
      logic [ACCW-1:0]       accum;
      logic [SLOTS-1:0]      flags;
      logic                  neg;
      logic                  point;
      logic [FCW-1:0]        fcount;
      logic                  err;
      logic                  stop;
      slot_type [SLOTS-1:0]  slots;
   } chan_state_type;

   typedef struct packed {
      logic [1:0]           src_channel;
      logic                 kind;
      logic [1:0]           cmd;
      logic [2:0]           status;
      logic                 clear_wait;
      logic [SLOTS-1:0]     flags;
      slot_type [SLOTS-1:0] slots;
   } raw_result_type;

   typedef struct packed {
      logic [1:0]                src_channel;
      logic                      kind;
      logic [1:0]                cmd;
      logic [2:0]                status;
      logic                      clear_wait;
      logic [SLOTS-1:0]          flags;
      logic [SLOTS-1:0][XW-1:0]  x;
      logic [SLOTS-1:0][KW-1:0]  k;
      logic [SLOTS-1:0]          neg;
   } scale_type;

   typedef struct packed {
      logic [1:0]              src_channel;
      logic                    kind;
      logic [1:0]              cmd;
      logic [2:0]              status;
      logic                    clear_wait;
      logic [SLOTS-1:0][31:0]  values;
      logic [SLOTS-1:0]        flags;
   } rsp_type;

endpackage

FILE: design/erlp_req_if.sv
// ----------------------------------------------------------------------------
// erlp_req_if
// Request channel: one received byte tagged with its link.
// ----------------------------------------------------------------------------
interface erlp_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] channel;
   logic [7:0] rx_byte;

   modport source (output valid, output channel, output rx_byte, input ready);
   modport sink   (input valid, input channel, input rx_byte, output ready);
endinterface

FILE: design/erlp_rsp_if.sv
// ----------------------------------------------------------------------------
// erlp_rsp_if
// Result channel: one parsed echo or status reply.
// ----------------------------------------------------------------------------
interface erlp_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         src_channel;
   logic               event_kind;
   logic [1:0]         command_code;
   logic [2:0]         status_code;
   logic               clear_wait;
   logic signed [31:0] rpm_value;
   logic signed [31:0] egt_value;
   logic signed [31:0] pump_milli;
   logic signed [31:0] engine_status;
   logic signed [31:0] throttle_milli;
   logic signed [31:0] current_milli;
   logic [5:0]         fields_valid;

   modport source (output valid, output src_channel, output event_kind,
                   output command_code, output status_code, output clear_wait,
                   output rpm_value, output egt_value, output pump_milli,
                   output engine_status, output throttle_milli,
                   output current_milli, output fields_valid, input ready);
   modport sink   (input valid, input src_channel, input event_kind,
                   input command_code, input status_code, input clear_wait,
                   input rpm_value, input egt_value, input pump_milli,
                   input engine_status, input throttle_milli,
                   input current_milli, input fields_valid, output ready);
endinterface

FILE: design/erlp_ram.sv
// ----------------------------------------------------------------------------
// erlp_ram
// Simple dual-port RAM, one write and one registered read, read before write.
// ----------------------------------------------------------------------------
module erlp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: design/ecu_reply_line_parser.sv
// ----------------------------------------------------------------------------
// ecu_reply_line_parser
// Per-link parser of carriage-return lines from engine control units.
//
// Bytes enter on req_port, each tagged with its link; a byte on a link at or
// above CHANNELS is taken and dropped. Every link keeps its own line parser
// state in one RAM entry, read through the registered RAM port and written
// back from the request stage; a byte on the same link in the following cycle
// picks the new state from a bypass register, so one request is taken every
// cycle while req_port.ready is high. A carriage return that closes a matched
// line yields one result on rsp_port: a command echo, or a status reply that
// has decoded fields only for an RAC OK reply. A result passes the request
// stage, a result register and the scaling pipeline (one multiply stage, then
// one divide by ten per stage) into an output FIFO; req_port.ready drops only
// when the FIFO plus requests in flight could fill it, so a stalled receiver
// can hold requests back before the FIFO is full. Reset clears every link to
// idle at once through per-link valid bits and empties the FIFO.
// ----------------------------------------------------------------------------
module ecu_reply_line_parser #(
   parameter int CHANNELS     = erlp_pkg::CHANNELS_DEF,
   parameter int MAX_FRACTION = erlp_pkg::MAX_FRACTION_DEF
) (
   input logic               clock,
   input logic               reset,
   erlp_req_if.sink          req_port,
   erlp_rsp_if.source        rsp_port
);
   import erlp_pkg::*;

   localparam int AW         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int DIV_STAGES = (MAX_FRACTION > 3) ? MAX_FRACTION - 3 : 0;
   localparam int DEPTH      = DIV_STAGES + 5;
   localparam int PW         = $clog2(DEPTH);
   localparam int CW         = $clog2(DEPTH + 1);
   localparam int SW         = $bits(chan_state_type);

   function automatic logic [2:0] status_of(input logic [7:0] a, input logic [7:0] c);
      logic [2:0] st;
      unique case ({a, c})
         "OK":    st = ST_OK;
         "UC":    st = ST_UC;
         "PA":    st = ST_PA;
         "NA":    st = ST_NA;
         "PR":    st = ST_PR;
         "PL":    st = ST_PL;
         "DF":    st = ST_DF;
         default: st = ST_UNKNOWN;
      endcase
      return st;
   endfunction

   function automatic chan_state_type field_begin(input chan_state_type s);
      chan_state_type r;
      r        = s;
      r.accum  = '0;
      r.neg    = 1'b0;
      r.point  = 1'b0;
      r.fcount = '0;
      r.err    = 1'b0;
      return r;
   endfunction

   function automatic chan_state_type scan_begin(input chan_state_type s);
      chan_state_type r;
      r       = field_begin(s);
      r.fidx  = 4'd1;
      r.flags = '0;
      r.stop  = 1'b0;
      return r;
   endfunction

   function automatic chan_state_type field_finish(input chan_state_type s);
      chan_state_type  r;
      logic [ACCW-1:0] mag;
      logic [ACCW-1:0] lim;
      logic [2:0]      slot;
      r = s;
      if (s.fidx >= 4'd3 && s.fidx <= 4'd8) begin
         slot = 3'(s.fidx - 4'd3);
         mag  = s.err ? '0 : s.accum;
         lim  = s.neg ? LIM_NEG : LIM_POS;
         if (mag > lim) begin
            mag = lim;
         end
         r.slots[slot].mag = mag[31:0];
         r.slots[slot].dx  = s.err ? '0 : s.fcount;
         r.slots[slot].neg = s.neg;
         r.flags[slot]     = 1'b1;
      end
      return r;
   endfunction

   function automatic chan_state_type scan_byte(input chan_state_type s, input logic [7:0] b);
      chan_state_type r;
      logic           in_field;
      logic [VW-1:0]  v;
      r        = s;
      in_field = (s.fidx >= 4'd3) && (s.fidx <= 4'd8);
      v        = ({3'b0, s.accum} << 3) + ({3'b0, s.accum} << 1) + VW'(b - CH_ZERO);
      if (!s.stop) begin
         if (b == CH_COMMA) begin
            r = field_finish(s);
            if (s.fidx < 4'd15) begin
               r.fidx = s.fidx + 4'd1;
            end
            r = field_begin(r);
         end else if (b == CH_STAR || b < CH_LOW || b > CH_HIGH) begin
            r.err  = 1'b1;
            r.stop = 1'b1;
         end else if (in_field) begin
            if (b == CH_MINUS) begin
               r.neg = 1'b1;
            end else if (b == CH_POINT) begin
               if (s.point) begin
                  r.err = 1'b1;
               end
               r.point = 1'b1;
            end else if (b >= CH_ZERO && b <= CH_NINE) begin
               if (!s.point || s.fcount < FCW'(MAX_FRACTION)) begin
                  r.accum = (v > {3'b0, MAG_CAP}) ? MAG_CAP : v[ACCW-1:0];
                  if (s.point) begin
                     r.fcount = s.fcount + FCW'(1);
                  end
               end
            end else begin
               r.err = 1'b1;
            end
         end
      end
      return r;
   endfunction

   // request stage
   logic           s1_valid_ff;
   logic [1:0]     s1_channel_ff;
   logic [7:0]     s1_byte_ff;
   logic           req_accept;
   logic           req_in_range;

   // bypass and per-link valid bits
   logic           fwd_valid_ff;
   logic [AW-1:0]  fwd_addr_ff;
   chan_state_type fwd_state_ff;
   logic [CHANNELS-1:0] chan_init_ff;
   logic [CHANNELS-1:0] chan_init_in;

   logic [SW-1:0]  ram_rd_data;
   logic [AW-1:0]  s1_addr;
   chan_state_type cur_state;
   chan_state_type nxt_state;
   raw_result_type s1_result;
   logic           s1_result_valid;

   raw_result_type r0_ff;
   logic           r0_valid_ff;

   scale_type      q_ff       [DIV_STAGES+1];
   scale_type      q_in       [DIV_STAGES+1];
   logic           q_valid_ff [DIV_STAGES+1];

   rsp_type        fifo_mem_ff [DEPTH];
   rsp_type        fin_result;
   logic [PW-1:0]  wr_ptr_ff;
   logic [PW-1:0]  rd_ptr_ff;
   logic [CW-1:0]  fifo_count_ff;
   logic [CW:0]    inflight;
   logic           fifo_push;
   logic           fifo_pop;

   assign req_in_range = 32'(req_port.channel) < CHANNELS;
   assign req_accept   = req_port.valid && req_port.ready;
   assign s1_addr      = AW'(s1_channel_ff);

   erlp_ram #(
      .WIDTH (SW),
      .DEPTH (CHANNELS)
   ) u_state_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff),
      .wr_addr (s1_addr),
      .wr_data (nxt_state),
      .rd_addr (AW'(req_port.channel)),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      if (fwd_valid_ff && fwd_addr_ff == s1_addr) begin
         cur_state = fwd_state_ff;
      end else if (chan_init_ff[s1_addr]) begin
         cur_state = chan_state_type'(ram_rd_data);
      end else begin
         cur_state = '0;
      end
   end

   always_comb begin
      logic [1:0] code;
      logic [2:0] st;
      chan_state_type fin;
      nxt_state       = cur_state;
      s1_result       = '0;
      s1_result_valid = 1'b0;
      code            = CMD_OTHER;
      st              = ST_UNKNOWN;
      fin             = field_finish(cur_state);
      s1_result.src_channel = s1_channel_ff;
      if (s1_byte_ff == CH_CR) begin
         if (cur_state.pending == PEND_IDLE && cur_state.pos >= 3'd2) begin
            if (cur_state.pos >= 3'd5) begin
               if ({cur_state.pfx[0], cur_state.pfx[1], cur_state.pfx[2]} == "RAC") begin
                  code = CMD_RAC;
               end else if ({cur_state.pfx[0], cur_state.pfx[1], cur_state.pfx[2]} == "WPE") begin
                  code = CMD_WPE;
               end else if ({cur_state.pfx[0], cur_state.pfx[1], cur_state.pfx[2]} == "TCO") begin
                  code = CMD_TCO;
               end
            end
            s1_result.kind    = KIND_ECHO;
            s1_result.cmd     = code;
            nxt_state.pending = (code != CMD_OTHER) ? code + 2'd1 : PEND_IDLE;
            s1_result_valid   = 1'b1;
         end else if (cur_state.pending != PEND_IDLE && cur_state.pos >= 3'd4) begin
            if (cur_state.pos == 3'd7) begin
               st = status_of(cur_state.pfx[3], cur_state.pfx[4]);
            end
            s1_result.kind       = KIND_STATUS;
            s1_result.cmd        = cur_state.pending - 2'd1;
            s1_result.status     = st;
            s1_result.clear_wait = (st != ST_UNKNOWN);
            if (cur_state.pending == CMD_RAC + 2'd1 && st == ST_OK) begin
               s1_result.flags = fin.flags;
               s1_result.slots = fin.slots;
            end
            nxt_state.pending = PEND_IDLE;
            s1_result_valid   = 1'b1;
         end
         nxt_state      = scan_begin(nxt_state);
         nxt_state.pos  = 3'd0;
         nxt_state.fidx = 4'd0;
      end else if (cur_state.pos == 3'd0) begin
         nxt_state.pos = (s1_byte_ff == CH_ONE) ? 3'd1 : 3'd0;
      end else if (cur_state.pos == 3'd1) begin
         if (s1_byte_ff == CH_COMMA) begin
            nxt_state     = scan_begin(cur_state);
            nxt_state.pos = 3'd2;
         end else begin
            nxt_state.pos = (s1_byte_ff == CH_ONE) ? 3'd1 : 3'd0;
         end
      end else if (cur_state.pending != PEND_IDLE &&
                   ((cur_state.pos == 3'd2 && s1_byte_ff != CH_H) ||
                    (cur_state.pos == 3'd3 && s1_byte_ff != CH_S))) begin
         nxt_state.pos = (s1_byte_ff == CH_ONE) ? 3'd1 : 3'd0;
      end else begin
         if (cur_state.pos < 3'd7) begin
            nxt_state.pfx[3'(cur_state.pos - 3'd2)] = s1_byte_ff;
            nxt_state.pos = cur_state.pos + 3'd1;
         end
         nxt_state = scan_byte(nxt_state, s1_byte_ff);
      end
   end

   always_comb begin
      chan_init_in = chan_init_ff;
      if (s1_valid_ff) begin
         chan_init_in[s1_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         fwd_valid_ff <= 1'b0;
         chan_init_ff <= '0;
         r0_valid_ff  <= 1'b0;
      end else begin
         s1_valid_ff  <= req_accept && req_in_range;
         fwd_valid_ff <= s1_valid_ff;
         chan_init_ff <= chan_init_in;
         r0_valid_ff  <= s1_valid_ff && s1_result_valid;
      end
      s1_channel_ff <= req_port.channel;
      s1_byte_ff    <= req_port.rx_byte;
      fwd_addr_ff   <= s1_addr;
      fwd_state_ff  <= nxt_state;
      r0_ff         <= s1_result;
   end

   // scaling: multiply up for few fraction digits, else divide by ten per stage
   always_comb begin
      logic [9:0]  fac;
      logic [63:0] prod;
      fac  = 10'd1000;
      prod = '0;
      q_in[0].src_channel = r0_ff.src_channel;
      q_in[0].kind        = r0_ff.kind;
      q_in[0].cmd         = r0_ff.cmd;
      q_in[0].status      = r0_ff.status;
      q_in[0].clear_wait  = r0_ff.clear_wait;
      q_in[0].flags       = r0_ff.flags;
      for (int j = 0; j < SLOTS; j++) begin
         q_in[0].neg[j] = r0_ff.slots[j].neg;
         q_in[0].x[j]   = XW'(r0_ff.slots[j].mag);
         q_in[0].k[j]   = '0;
         if (SCALED_SLOTS[j]) begin
            if (r0_ff.slots[j].dx < FCW'(3)) begin
               case (r0_ff.slots[j].dx)
                  FCW'(0): fac = 10'd1000;
                  FCW'(1): fac = 10'd100;
                  default: fac = 10'd10;
               endcase
               q_in[0].x[j] = XW'(r0_ff.slots[j].mag) * XW'(fac);
            end else begin
               q_in[0].k[j] = KW'(r0_ff.slots[j].dx - FCW'(3));
            end
         end
      end
      for (int i = 1; i <= DIV_STAGES; i++) begin
         q_in[i] = q_ff[i-1];
         for (int j = 0; j < SLOTS; j++) begin
            if (SCALED_SLOTS[j] && q_ff[i-1].k[j] != '0) begin
               prod         = 64'(q_ff[i-1].x[j][31:0]) * 64'hcccc_cccd;
               q_in[i].x[j] = XW'(prod[63:35]);
               q_in[i].k[j] = q_ff[i-1].k[j] - KW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= DIV_STAGES; i++) begin
            q_valid_ff[i] <= 1'b0;
         end
      end else begin
         q_valid_ff[0] <= r0_valid_ff;
         for (int i = 1; i <= DIV_STAGES; i++) begin
            q_valid_ff[i] <= q_valid_ff[i-1];
         end
      end
      for (int i = 0; i <= DIV_STAGES; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   always_comb begin
      logic [31:0] v;
      fin_result.src_channel = q_ff[DIV_STAGES].src_channel;
      fin_result.kind        = q_ff[DIV_STAGES].kind;
      fin_result.cmd         = q_ff[DIV_STAGES].cmd;
      fin_result.status      = q_ff[DIV_STAGES].status;
      fin_result.clear_wait  = q_ff[DIV_STAGES].clear_wait;
      fin_result.flags       = q_ff[DIV_STAGES].flags;
      for (int j = 0; j < SLOTS; j++) begin
         if (q_ff[DIV_STAGES].neg[j]) begin
            v = (q_ff[DIV_STAGES].x[j] >= XW'(33'h0_8000_0000)) ? 32'h8000_0000 :
                32'h0 - q_ff[DIV_STAGES].x[j][31:0];
         end else begin
            v = (q_ff[DIV_STAGES].x[j] > XW'(32'h7fff_ffff)) ? 32'h7fff_ffff :
                q_ff[DIV_STAGES].x[j][31:0];
         end
         fin_result.values[j] = q_ff[DIV_STAGES].flags[j] ? v : 32'h0;
      end
   end

   // output queue
   assign fifo_push = q_valid_ff[DIV_STAGES];
   assign fifo_pop  = rsp_port.valid && rsp_port.ready;

   always_comb begin
      inflight = (CW+1)'(s1_valid_ff) + (CW+1)'(r0_valid_ff);
      for (int i = 0; i <= DIV_STAGES; i++) begin
         inflight = inflight + (CW+1)'(q_valid_ff[i]);
      end
   end

   assign req_port.ready = ((CW+1)'(fifo_count_ff) + inflight) < (CW+1)'(DEPTH);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff     <= '0;
         rd_ptr_ff     <= '0;
         fifo_count_ff <= '0;
      end else begin
         if (fifo_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (fifo_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (fifo_push && !fifo_pop) begin
            fifo_count_ff <= fifo_count_ff + CW'(1);
         end else if (!fifo_push && fifo_pop) begin
            fifo_count_ff <= fifo_count_ff - CW'(1);
         end
      end
      if (fifo_push) begin
         fifo_mem_ff[wr_ptr_ff] <= fin_result;
      end
   end

   assign rsp_port.valid          = (fifo_count_ff != '0);
   assign rsp_port.src_channel    = fifo_mem_ff[rd_ptr_ff].src_channel;
   assign rsp_port.event_kind     = fifo_mem_ff[rd_ptr_ff].kind;
   assign rsp_port.command_code   = fifo_mem_ff[rd_ptr_ff].cmd;
   assign rsp_port.status_code    = fifo_mem_ff[rd_ptr_ff].status;
   assign rsp_port.clear_wait     = fifo_mem_ff[rd_ptr_ff].clear_wait;
   assign rsp_port.rpm_value      = fifo_mem_ff[rd_ptr_ff].values[0];
   assign rsp_port.egt_value      = fifo_mem_ff[rd_ptr_ff].values[1];
   assign rsp_port.pump_milli     = fifo_mem_ff[rd_ptr_ff].values[2];
   assign rsp_port.engine_status  = fifo_mem_ff[rd_ptr_ff].values[3];
   assign rsp_port.throttle_milli = fifo_mem_ff[rd_ptr_ff].values[4];
   assign rsp_port.current_milli  = fifo_mem_ff[rd_ptr_ff].values[5];
   assign rsp_port.fields_valid   = fifo_mem_ff[rd_ptr_ff].flags;

   a_fifo_bound: assert property (@(posedge clock) disable iff (reset)
      ((CW+1)'(fifo_count_ff) + inflight) <= (CW+1)'(DEPTH))
      else $error("output queue over-committed");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      fifo_push |-> (fifo_count_ff < CW'(DEPTH) || fifo_pop))
      else $error("result pushed into a full queue");

   a_fields_only_rac_ok: assert property (@(posedge clock) disable iff (reset)
      (r0_valid_ff && r0_ff.flags != '0) |->
      (r0_ff.kind == KIND_STATUS && r0_ff.cmd == CMD_RAC && r0_ff.status == ST_OK))
      else $error("decoded fields outside a RAC OK reply");

   a_echo_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_port.valid && rsp_port.event_kind == KIND_ECHO) |->
      (rsp_port.clear_wait == 1'b0 && rsp_port.status_code == ST_OK))
      else $error("echo carries status");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_port.valid)
      else $error("result present after reset");
endmodule

FILE: tb/ecu_reply_line_parser_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ecu_reply_line_parser_test
// Drives received bytes on four links through the engine reply line parser
// and checks every echo and status reply against a per-link line predictor,
// with random idling on both sides and a long receiver hold-off.
// ----------------------------------------------------------------------------
module ecu_reply_line_parser_test;
   import erlp_pkg::*;

   localparam int NLINK    = 4;
   localparam int FRAC_MAX = 5;
   localparam int WD_LIMIT = 4000;
   localparam int HOLD_LEN = 300;
   localparam logic [63:0] ACC_CAP = 64'h100_0000_0000;

   logic clock;
   logic reset;

   erlp_req_if req_if ();
   erlp_rsp_if rsp_if ();

   ecu_reply_line_parser uut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_if.sink),
      .rsp_port (rsp_if.source)
   );

   // per-link line state
   logic [1:0]  lk_pend  [NLINK];
   int          lk_pos   [NLINK];
   logic [7:0]  lk_pfx   [NLINK][5];
   int          lk_fidx  [NLINK];
   logic [63:0] lk_acc   [NLINK];
   logic [5:0]  lk_flags [NLINK];
   logic [31:0] lk_vals  [NLINK][6];
   bit          lk_neg   [NLINK];
   bit          lk_point [NLINK];
   int          lk_fcnt  [NLINK];
   bit          lk_err   [NLINK];
   bit          lk_stop  [NLINK];

   rsp_type reply_q[$];

   int  n_requests;
   int  n_replies;
   int  n_errors;
   int  idle_cycles;
   bit  calm;
   bit  hold_start;
   int  hold_left;
   int  stall_left;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void field_open(int c);
      lk_acc[c]   = '0;
      lk_neg[c]   = 1'b0;
      lk_point[c] = 1'b0;
      lk_fcnt[c]  = 0;
      lk_err[c]   = 1'b0;
   endfunction

   function automatic void field_close(int c);
      int          slot;
      int          dx;
      logic [63:0] mag;
      logic [63:0] lim;
      if (lk_fidx[c] < 3 || lk_fidx[c] > 8) return;
      slot = lk_fidx[c] - 3;
      mag  = lk_err[c] ? 64'd0 : lk_acc[c];
      dx   = lk_err[c] ? 0 : lk_fcnt[c];
      lim  = lk_neg[c] ? 64'h8000_0000 : 64'h7fff_ffff;
      if (mag > lim) mag = lim;
      if (slot == 2 || slot == 4 || slot == 5) begin
         mag = mag * 1000;
         repeat (dx) mag = mag / 10;
      end
      if (lk_neg[c])
         lk_vals[c][slot] = (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'd0 - mag[31:0];
      else
         lk_vals[c][slot] = (mag > 64'h7fff_ffff) ? 32'h7fff_ffff : mag[31:0];
      lk_flags[c][slot] = 1'b1;
   endfunction

   function automatic void scan_open(int c);
      lk_fidx[c]  = 1;
      lk_flags[c] = '0;
      lk_stop[c]  = 1'b0;
      for (int i = 0; i < 6; i++) lk_vals[c][i] = '0;
      field_open(c);
   endfunction

   function automatic void scan_char(int c, logic [7:0] b);
      bit          in_field;
      logic [63:0] v;
      in_field = lk_fidx[c] >= 3 && lk_fidx[c] <= 8;
      if (lk_stop[c]) return;
      if (b == CH_COMMA) begin
         field_close(c);
         if (lk_fidx[c] < 15) lk_fidx[c]++;
         field_open(c);
         return;
      end
      if (b == CH_STAR || b < CH_LOW || b > CH_HIGH) begin
         lk_err[c]  = 1'b1;
         lk_stop[c] = 1'b1;
         return;
      end
      if (!in_field) return;
      if (b == CH_MINUS) lk_neg[c] = 1'b1;
      else if (b == CH_POINT) begin
         if (lk_point[c]) lk_err[c] = 1'b1;
         lk_point[c] = 1'b1;
      end else if (b >= CH_ZERO && b <= CH_NINE) begin
         if (!lk_point[c] || lk_fcnt[c] < FRAC_MAX) begin
            v = lk_acc[c] * 10 + (b - CH_ZERO);
            lk_acc[c] = (v > ACC_CAP) ? ACC_CAP : v;
            if (lk_point[c]) lk_fcnt[c]++;
         end
      end else lk_err[c] = 1'b1;
   endfunction

   function automatic logic [2:0] status_of(logic [7:0] a, logic [7:0] b);
      case ({a, b})
         "OK": return ST_OK;
         "UC": return ST_UC;
         "PA": return ST_PA;
         "NA": return ST_NA;
         "PR": return ST_PR;
         "PL": return ST_PL;
         "DF": return ST_DF;
         default: return ST_UNKNOWN;
      endcase
   endfunction

   function automatic void close_line(int c);
      rsp_type r;
      logic [1:0] code;
      r = '0;
      r.src_channel = c[1:0];
      if (lk_pend[c] == PEND_IDLE && lk_pos[c] >= 2) begin
         code = CMD_OTHER;
         if (lk_pos[c] >= 5) begin
            if ({lk_pfx[c][0], lk_pfx[c][1], lk_pfx[c][2]} == "RAC") code = CMD_RAC;
            else if ({lk_pfx[c][0], lk_pfx[c][1], lk_pfx[c][2]} == "WPE") code = CMD_WPE;
            else if ({lk_pfx[c][0], lk_pfx[c][1], lk_pfx[c][2]} == "TCO") code = CMD_TCO;
         end
         r.kind = KIND_ECHO;
         r.cmd  = code;
         lk_pend[c] = (code != CMD_OTHER) ? code + 2'd1 : PEND_IDLE;
         reply_q.push_back(r);
      end else if (lk_pend[c] != PEND_IDLE && lk_pos[c] >= 4) begin
         r.kind       = KIND_STATUS;
         r.cmd        = lk_pend[c] - 2'd1;
         r.status     = (lk_pos[c] >= 7) ? status_of(lk_pfx[c][3], lk_pfx[c][4]) : ST_UNKNOWN;
         r.clear_wait = r.status != ST_UNKNOWN;
         if (r.cmd == CMD_RAC && r.status == ST_OK) begin
            field_close(c);
            for (int i = 0; i < 6; i++)
               if (lk_flags[c][i]) r.values[i] = lk_vals[c][i];
            r.flags = lk_flags[c];
         end
         lk_pend[c] = PEND_IDLE;
         reply_q.push_back(r);
      end
      lk_pos[c] = 0;
      scan_open(c);
      lk_fidx[c] = 0;
   endfunction

   function automatic void predict_byte(int c, logic [7:0] b);
      if (b == CH_CR) begin
         close_line(c);
         return;
      end
      if (lk_pos[c] == 0) lk_pos[c] = (b == CH_ONE);
      else if (lk_pos[c] == 1) begin
         if (b == CH_COMMA) begin
            lk_pos[c] = 2;
            scan_open(c);
         end else lk_pos[c] = (b == CH_ONE);
      end else begin
         if (lk_pend[c] != PEND_IDLE &&
             ((lk_pos[c] == 2 && b != CH_H) || (lk_pos[c] == 3 && b != CH_S))) begin
            lk_pos[c] = (b == CH_ONE);
            return;
         end
         if (lk_pos[c] < 7) begin
            lk_pfx[c][lk_pos[c] - 2] = b;
            lk_pos[c]++;
         end
         scan_char(c, b);
      end
   endfunction

   function automatic void check_reply();
      rsp_type act;
      rsp_type want;
      act.src_channel = rsp_if.src_channel;
      act.kind        = rsp_if.event_kind;
      act.cmd         = rsp_if.command_code;
      act.status      = rsp_if.status_code;
      act.clear_wait  = rsp_if.clear_wait;
      act.values[0]   = rsp_if.rpm_value;
      act.values[1]   = rsp_if.egt_value;
      act.values[2]   = rsp_if.pump_milli;
      act.values[3]   = rsp_if.engine_status;
      act.values[4]   = rsp_if.throttle_milli;
      act.values[5]   = rsp_if.current_milli;
      act.flags       = rsp_if.fields_valid;
      n_replies++;
      if (reply_q.size() == 0) begin
         n_errors++;
         if (n_errors <= 10) $display("unexpected reply: %p", act);
         return;
      end
      want = reply_q.pop_front();
      if (act.src_channel !== want.src_channel || act.kind !== want.kind ||
          act.cmd !== want.cmd || act.status !== want.status ||
          act.clear_wait !== want.clear_wait || act.flags !== want.flags ||
          act.values !== want.values) begin
         n_errors++;
         if (n_errors <= 10) $display("reply mismatch\n  exp %p\n  got %p", want, act);
      end
   endfunction

   // receiver: check, random stalls, one long hold-off on request
   always @(posedge clock) begin
      if (reset) rsp_if.ready <= 1'b0;
      else begin
         if (rsp_if.valid && rsp_if.ready) check_reply();
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = HOLD_LEN - 1;
            rsp_if.ready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_if.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            rsp_if.ready <= 1'b0;
         end else rsp_if.ready <= 1'b1;
      end
   end

   // watchdog on cycles with no request or reply taken
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) idle_cycles = 0;
      else if (!reset) idle_cycles++;
      if (idle_cycles >= WD_LIMIT) begin
         $display("watchdog expired, %0d replies outstanding", reply_q.size());
         $display("ecu_reply_line_parser test failed");
         $finish;
      end
   end

   task automatic send_byte(int c, logic [7:0] b);
      if (!calm && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
      end
      req_if.valid   <= 1'b1;
      req_if.channel <= c[1:0];
      req_if.rx_byte <= b;
      do @(posedge clock); while (!req_if.ready);
      predict_byte(c, b);
      n_requests++;
   endtask

   task automatic send_line(int c, string s);
      for (int i = 0; i < s.len(); i++) send_byte(c, s[i]);
      send_byte(c, CH_CR);
   endtask

   // merge two lines on different links byte by byte
   task automatic send_merged(int c0, string s0, int c1, string s1);
      int i;
      int j;
      i = 0;
      j = 0;
      while (i <= s0.len() || j <= s1.len()) begin
         if (j > s1.len() || (i <= s0.len() && $urandom_range(0, 1))) begin
            send_byte(c0, (i < s0.len()) ? s0[i] : CH_CR);
            i++;
         end else begin
            send_byte(c1, (j < s1.len()) ? s1[j] : CH_CR);
            j++;
         end
      end
   endtask

   task automatic drain();
      req_if.valid <= 1'b0;
      while (reply_q.size() != 0) @(posedge clock);
   endtask

   function automatic string rand_number();
      string s;
      s = "";
      if ($urandom_range(0, 3) == 0) s = "-";
      repeat ($urandom_range(0, ($urandom_range(0, 5) == 0) ? 15 : 5))
         s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      if ($urandom_range(0, 1)) begin
         s = {s, "."};
         repeat ($urandom_range(0, 8)) s = {s, string'(8'(CH_ZERO + $urandom_range(0, 9)))};
      end
      case ($urandom_range(0, 19))
         0: s = {s, "x"};
         1: s = {s, "."};
         2: s = {s, "*"};
         3: s = {s, string'(8'($urandom_range(128, 255)))};
         4: s = {"-", s};
         default: ;
      endcase
      return s;
   endfunction

   function automatic string rand_line(int c);
      string pairs[8];
      string cmds[4];
      string s;
      pairs = '{"OK", "UC", "PA", "NA", "PR", "PL", "DF", "OX"};
      cmds  = '{"RAC", "WPE", "TCO", "RPM"};
      if ($urandom_range(0, 9) == 0) begin
         s = "";
         repeat ($urandom_range(0, 12)) s = {s, string'(8'($urandom_range(1, 255)))};
         return s;
      end
      if (lk_pend[c] == PEND_IDLE) return {"1,", cmds[$urandom_range(0, 3)], ",", rand_number()};
      s = ($urandom_range(0, 5) == 0) ? "1,AB,1,HS," : "1,HS,";
      s = {s, (lk_pend[c] == 2'd1 && $urandom_range(0, 2) != 0) ? "OK" : pairs[$urandom_range(0, 7)]};
      repeat ($urandom_range(0, 8)) s = {s, ",", rand_number()};
      return s;
   endfunction

   task automatic test_directed();
      send_line(0, "1,RAC");
      send_line(0, "1,HS,OK,12345.678901,-40,12.5,3,99.99999,-0.001");
      send_line(1, "1,RAC");
      send_line(1, "1,HS,OK,99999999999999,-99999999999999,9999999999,-5.,2147483.647,.");
      send_line(2, "1,WPE");
      send_line(2, "1,HS,UC");
      send_line(3, "1,TCO");
      send_line(3, "1,HS,PA");
      send_line(0, "1,RAC");
      send_line(0, "1,HS,OK,1.2.3,4x,5*,6,7");
      send_line(1, "1,RA");
      send_line(1, "no start");
      send_line(1, "11,WPE");
      send_line(1, "xx1,XY1,HS,NA");
      send_line(1, "1,HS");
      send_line(2, "1,TCO");
      send_line(2, "1,H");
      send_line(2, "1,HS");
      for (int i = 0; i < 4; i++) begin
         send_line(3, "1,WPE");
         send_line(3, i == 0 ? "1,HS,PR" : i == 1 ? "1,HS,PL" : i == 2 ? "1,HS,DF" : "1,HS,ZZ");
      end
      send_byte(0, 8'h00);
      send_byte(3, 8'hff);
      send_line(0, {"1,", string'(8'h80)});
   endtask

   task automatic test_random(int count);
      int c0;
      int c1;
      while (n_requests < count) begin
         c0 = $urandom_range(0, NLINK - 1);
         c1 = (c0 + $urandom_range(1, NLINK - 1)) % NLINK;
         send_merged(c0, rand_line(c0), c1, rand_line(c1));
      end
   endtask

   task automatic test_backpressure();
      hold_start = 1'b1;
      repeat (40) begin
         send_line(2, "1,WPE");
         send_line(2, "1,HS,DF");
      end
   endtask

   task automatic test_pause();
      drain();
      test_random(n_requests + 60);
   endtask

   initial begin
      reset = 1'b1;
      calm = 1'b0;
      hold_start = 1'b0;
      hold_left = 0;
      stall_left = 0;
      n_requests = 0;
      n_replies = 0;
      n_errors = 0;
      idle_cycles = 0;
      req_if.valid = 1'b0;
      req_if.channel = '0;
      req_if.rx_byte = '0;
      rsp_if.ready = 1'b0;
      for (int c = 0; c < NLINK; c++) begin
         lk_pend[c] = PEND_IDLE;
         lk_pos[c] = 0;
         for (int i = 0; i < 5; i++) lk_pfx[c][i] = '0;
         scan_open(c);
         lk_fidx[c] = 0;
      end
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_backpressure();
      test_pause();
      test_random(800);
      calm = 1'b1;
      test_random(950);
      drain();
      repeat (20) @(posedge clock);
      $display("%0d bytes sent over %0d links, %0d echoes and replies checked",
               n_requests, NLINK, n_replies);
      if (n_errors == 0 && reply_q.size() == 0) $display("ecu_reply_line_parser test passed");
      else begin
         $display("%0d mismatches, %0d replies missing", n_errors, reply_q.size());
         $display("ecu_reply_line_parser test failed");
      end
      $finish;
   end

endmodule

FILE: ecu_reply_line_parser.f
design/erlp_pkg.sv
design/erlp_req_if.sv
design/erlp_rsp_if.sv
design/erlp_ram.sv
design/ecu_reply_line_parser.sv
tb/ecu_reply_line_parser_test.sv
